[rtl/utf8_stream_decoder_macros.svh]
// Assertion macros used by the checker file of the UTF-8 stream decoder.
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

// Property checked on every clock edge outside reset.
`define U8SD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Overlapping implication checked outside reset.
`define U8SD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define U8SD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/u8sd_pkg.sv]
// Types and constants shared by the UTF-8 stream decoder modules.
package u8sd_pkg;

	localparam int CP_WIDTH         = 21;
	localparam int SEQ_BYTES_WIDTH  = 3;
	localparam int CHAR_INDEX_WIDTH = 16;

	localparam logic [7:0] MASK_CONT  = 8'h3f;
	localparam logic [7:0] MASK_LEAD2 = 8'h1f;
	localparam logic [7:0] MASK_LEAD3 = 8'h0f;
	localparam logic [7:0] MASK_LEAD4 = 8'h07;

	localparam logic [SEQ_BYTES_WIDTH-1:0] LEN_ONE   = 3'd1;
	localparam logic [SEQ_BYTES_WIDTH-1:0] LEN_TWO   = 3'd2;
	localparam logic [SEQ_BYTES_WIDTH-1:0] LEN_THREE = 3'd3;
	localparam logic [SEQ_BYTES_WIDTH-1:0] LEN_FOUR  = 3'd4;

	typedef struct packed {
		logic [1:0]                 pending;
		logic [CP_WIDTH-1:0]        partial;
		logic [SEQ_BYTES_WIDTH-1:0] len;
	} seq_state_t;

	typedef struct packed {
		logic [CP_WIDTH-1:0]        code_point;
		logic [SEQ_BYTES_WIDTH-1:0] seq_bytes;
		logic                       bad_lead;
		logic                       truncated;
		logic                       last;
	} result_t;

endpackage

[rtl/u8sd_decode.sv]
// Combinational decode of one byte against the current sequence state.
module u8sd_decode
	import u8sd_pkg::*;
(
	input  logic [7:0] data,
	input  logic       eos,
	input  seq_state_t cur,
	output seq_state_t nxt,
	output logic       emit,
	output result_t    res
);

	logic [CP_WIDTH-1:0]        shifted;
	logic [1:0]                 pend_dec;
	logic [SEQ_BYTES_WIDTH-1:0] got;

	assign shifted  = {cur.partial[CP_WIDTH-7:0], data[5:0] & MASK_CONT[5:0]};
	assign pend_dec = cur.pending - 2'd1;

	always_comb begin
		nxt  = cur;
		emit = 1'b0;
		res  = '0;
		got  = '0;
		if (cur.pending == 2'd0) begin
			unique case (data) inside
				8'b0???????: begin
					emit           = 1'b1;
					res.code_point = CP_WIDTH'(data[6:0]);
					res.seq_bytes  = LEN_ONE;
				end
				8'b110?????: begin
					nxt.partial = CP_WIDTH'(data & MASK_LEAD2);
					nxt.len     = LEN_TWO;
					nxt.pending = 2'd1;
				end
				8'b1110????: begin
					nxt.partial = CP_WIDTH'(data & MASK_LEAD3);
					nxt.len     = LEN_THREE;
					nxt.pending = 2'd2;
				end
				8'b11110???: begin
					nxt.partial = CP_WIDTH'(data & MASK_LEAD4);
					nxt.len     = LEN_FOUR;
					nxt.pending = 2'd3;
				end
				default: begin
					emit          = 1'b1;
					res.seq_bytes = LEN_ONE;
					res.bad_lead  = 1'b1;
				end
			endcase
		end else begin
			nxt.partial = shifted;
			nxt.pending = pend_dec;
			if (pend_dec == 2'd0) begin
				emit           = 1'b1;
				res.code_point = shifted;
				res.seq_bytes  = cur.len;
				nxt            = '0;
			end
		end
		if (eos) begin
			if (!emit) begin
				got           = nxt.len - {1'b0, nxt.pending};
				emit          = 1'b1;
				res           = '0;
				res.seq_bytes = got;
				res.truncated = 1'b1;
			end
			res.last = 1'b1;
			nxt      = '0;
		end
	end

endmodule

[rtl/utf8_stream_decoder.sv]
// Top level of the UTF-8 stream decoder: input register, decode and result register.
//
//   channel   valid          stall          payload
//   byte      byte_valid     byte_stall     data_byte, end_of_string
//   result    result_valid   result_stall   code_point, seq_bytes, bad_lead,
//                                           truncated, char_index, last
//
// One byte per cycle is taken unless byte_stall; the result register takes each decoded result.
// The sequence state and the index counter update in the single decode pass.
// Reset clears the sequence state, the index counter and both valid flags.
// A stalled result holds; the input register keeps accepting until it is full.
module utf8_stream_decoder
	import u8sd_pkg::*;
#(
	parameter int INDEX_WIDTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        byte_valid,
	output logic                        byte_stall,
	input  logic [7:0]                  data_byte,
	input  logic                        end_of_string,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [CP_WIDTH-1:0]         code_point,
	output logic [SEQ_BYTES_WIDTH-1:0]  seq_bytes,
	output logic                        bad_lead,
	output logic                        truncated,
	output logic [CHAR_INDEX_WIDTH-1:0] char_index,
	output logic                        last
);

	logic                        valid_s1;
	logic [7:0]                  data_s1;
	logic                        eos_s1;
	seq_state_t                  seq_q;
	seq_state_t                  seq_nxt;
	logic [INDEX_WIDTH-1:0]      count_q;
	logic                        emit;
	result_t                     res;
	logic                        advance;
	logic                        accept;
	logic [CHAR_INDEX_WIDTH-1:0] index_fit;
	logic                        valid_s2;
	result_t                     result_s2;
	logic [CHAR_INDEX_WIDTH-1:0] index_s2;

	u8sd_decode u_decode (
		.data (data_s1),
		.eos  (eos_s1),
		.cur  (seq_q),
		.nxt  (seq_nxt),
		.emit (emit),
		.res  (res)
	);

	generate
		if (INDEX_WIDTH >= CHAR_INDEX_WIDTH) begin : g_idx_trunc
			assign index_fit = count_q[CHAR_INDEX_WIDTH-1:0];
		end else begin : g_idx_ext
			assign index_fit = {{(CHAR_INDEX_WIDTH-INDEX_WIDTH){1'b0}}, count_q};
		end
	endgenerate

	assign advance    = valid_s1 && (!valid_s2 || !result_stall);
	assign byte_stall = valid_s1 && !advance;
	assign accept     = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= data_byte;
			eos_s1  <= end_of_string;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q   <= '0;
			count_q <= '0;
		end else if (advance) begin
			seq_q <= seq_nxt;
			if (eos_s1) begin
				count_q <= '0;
			end else if (emit && (count_q != '1)) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= emit;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			result_s2 <= res;
			index_s2  <= index_fit;
		end
	end

	assign result_valid = valid_s2;
	assign code_point   = result_s2.code_point;
	assign seq_bytes    = result_s2.seq_bytes;
	assign bad_lead     = result_s2.bad_lead;
	assign truncated    = result_s2.truncated;
	assign last         = result_s2.last;
	assign char_index   = index_s2;

endmodule

[rtl/u8sd_checker.sv]
// Port-level checker for the UTF-8 stream decoder and its bind statement.
`include "utf8_stream_decoder_macros.svh"

module u8sd_checker
	import u8sd_pkg::*;
(
	input logic                        clk,
	input logic                        arst_n,
	input logic                        byte_valid,
	input logic                        byte_stall,
	input logic [7:0]                  data_byte,
	input logic                        end_of_string,
	input logic                        result_valid,
	input logic                        result_stall,
	input logic [CP_WIDTH-1:0]         code_point,
	input logic [SEQ_BYTES_WIDTH-1:0]  seq_bytes,
	input logic                        bad_lead,
	input logic                        truncated,
	input logic [CHAR_INDEX_WIDTH-1:0] char_index,
	input logic                        last
);

	`U8SD_ASSERT_NXT(a_result_holds, result_valid && result_stall, result_valid && $stable(code_point), "Stalled result beat changed or vanished.")
	`U8SD_ASSERT(a_flags_exclusive, !(result_valid && bad_lead && truncated), "Bad lead and truncation flagged together.")
	`U8SD_ASSERT_IMP(a_trunc_closes, result_valid && truncated, last && (code_point == '0) && (seq_bytes != LEN_FOUR), "Truncated beat is malformed.")
	`U8SD_ASSERT_IMP(a_bad_one_byte, result_valid && bad_lead, (seq_bytes == LEN_ONE) && (code_point == '0), "Bad lead beat is malformed.")

endmodule

bind utf8_stream_decoder u8sd_checker u_u8sd_checker (.*);

[bench/utf8_stream_decoder_test.sv]
// Self-checking testbench for the UTF-8 stream decoder: directed table, then random strings.
`timescale 1ns / 1ps

module utf8_stream_decoder_test;
	import u8sd_pkg::*;

	localparam int CLK_PERIOD  = 10;
	localparam int INDEX_WIDTH = 16;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_WAIT  = 20;
	localparam int PHASE_ITEMS = 300;
	localparam int N_DIRECTED  = 24;

	typedef struct packed {
		logic [CP_WIDTH-1:0]         cp;
		logic [SEQ_BYTES_WIDTH-1:0]  nbytes;
		logic                        bad;
		logic                        trunc;
		logic [CHAR_INDEX_WIDTH-1:0] idx;
		logic                        lst;
	} decoded_t;

	typedef struct packed {
		logic [7:0] b;
		logic       eos;
		logic       typed;
		decoded_t   want;
	} byte_row_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        byte_valid = 1'b0;
	logic                        byte_stall;
	logic [7:0]                  data_byte = 8'h00;
	logic                        end_of_string = 1'b0;
	logic                        result_valid;
	logic                        result_stall = 1'b0;
	logic [CP_WIDTH-1:0]         code_point;
	logic [SEQ_BYTES_WIDTH-1:0]  seq_bytes;
	logic                        bad_lead;
	logic                        truncated;
	logic [CHAR_INDEX_WIDTH-1:0] char_index;
	logic                        last;

	decoded_t pending_points [$];
	int       fail_count = 0;
	int       cycle_count = 0;
	int       send_idle_pct = 0;
	int       recv_stall_pct = 0;

	logic [1:0]                  cont_left = '0;
	logic [CP_WIDTH-1:0]         cp_accum = '0;
	logic [SEQ_BYTES_WIDTH-1:0]  cur_len = '0;
	logic [INDEX_WIDTH-1:0]      point_index = '0;

	byte_row_t directed_rows [N_DIRECTED] = '{
		'{8'h00, 1'b0, 1'b1, '{21'h0, LEN_ONE, 1'b0, 1'b0, 16'd0, 1'b0}},
		'{8'h7f, 1'b0, 1'b1, '{21'h7f, LEN_ONE, 1'b0, 1'b0, 16'd1, 1'b0}},
		'{8'hc3, 1'b0, 1'b0, '0},
		'{8'ha9, 1'b0, 1'b0, '0},
		'{8'he2, 1'b0, 1'b0, '0},
		'{8'h82, 1'b0, 1'b0, '0},
		'{8'hac, 1'b0, 1'b0, '0},
		'{8'hf0, 1'b0, 1'b0, '0},
		'{8'h9f, 1'b0, 1'b0, '0},
		'{8'h98, 1'b0, 1'b0, '0},
		'{8'h80, 1'b0, 1'b0, '0},
		'{8'h80, 1'b0, 1'b1, '{21'h0, LEN_ONE, 1'b1, 1'b0, 16'd5, 1'b0}},
		'{8'hff, 1'b0, 1'b1, '{21'h0, LEN_ONE, 1'b1, 1'b0, 16'd6, 1'b0}},
		'{8'hf8, 1'b1, 1'b1, '{21'h0, LEN_ONE, 1'b1, 1'b0, 16'd7, 1'b1}},
		'{8'he0, 1'b0, 1'b0, '0},
		'{8'hbf, 1'b1, 1'b1, '{21'h0, LEN_TWO, 1'b0, 1'b1, 16'd0, 1'b1}},
		'{8'hf7, 1'b1, 1'b1, '{21'h0, LEN_ONE, 1'b0, 1'b1, 16'd0, 1'b1}},
		'{8'hdf, 1'b0, 1'b0, '0},
		'{8'hff, 1'b0, 1'b0, '0},
		'{8'hf7, 1'b0, 1'b0, '0},
		'{8'hbf, 1'b0, 1'b0, '0},
		'{8'hbf, 1'b0, 1'b0, '0},
		'{8'hbf, 1'b1, 1'b0, '0},
		'{8'h41, 1'b1, 1'b1, '{21'h41, LEN_ONE, 1'b0, 1'b0, 16'd0, 1'b1}}
	};

	utf8_stream_decoder #(
		.INDEX_WIDTH(INDEX_WIDTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.data_byte(data_byte),
		.end_of_string(end_of_string),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.code_point(code_point),
		.seq_bytes(seq_bytes),
		.bad_lead(bad_lead),
		.truncated(truncated),
		.char_index(char_index),
		.last(last)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic decoded_t make_point(input logic [CP_WIDTH-1:0] cp,
			input logic [SEQ_BYTES_WIDTH-1:0] nbytes, input logic bad, input logic trunc,
			input logic lst);
		decoded_t res;
		res = '{cp, nbytes, bad, trunc, CHAR_INDEX_WIDTH'(point_index), lst};
		if (point_index != '1) begin
			point_index = point_index + 1'b1;
		end
		return res;
	endfunction

	function automatic bit decode_byte(input logic [7:0] b, input logic eos,
			output decoded_t res);
		bit made;
		made = 1'b0;
		res = '0;
		if (cont_left == 2'd0) begin
			casez (b)
				8'b0???????: begin
					res = make_point(CP_WIDTH'(b), LEN_ONE, 1'b0, 1'b0, eos);
					made = 1'b1;
				end
				8'b110?????: begin
					cp_accum = CP_WIDTH'(b & MASK_LEAD2);
					cur_len = LEN_TWO;
					cont_left = 2'd1;
				end
				8'b1110????: begin
					cp_accum = CP_WIDTH'(b & MASK_LEAD3);
					cur_len = LEN_THREE;
					cont_left = 2'd2;
				end
				8'b11110???: begin
					cp_accum = CP_WIDTH'(b & MASK_LEAD4);
					cur_len = LEN_FOUR;
					cont_left = 2'd3;
				end
				default: begin
					res = make_point('0, LEN_ONE, 1'b1, 1'b0, eos);
					made = 1'b1;
				end
			endcase
		end else begin
			cp_accum = (cp_accum << 6) | CP_WIDTH'(b & MASK_CONT);
			cont_left = cont_left - 1'b1;
			if (cont_left == 2'd0) begin
				res = make_point(cp_accum, cur_len, 1'b0, 1'b0, eos);
				made = 1'b1;
				cp_accum = '0;
				cur_len = '0;
			end
		end
		if (eos) begin
			if (!made) begin
				res = make_point('0, cur_len - SEQ_BYTES_WIDTH'(cont_left), 1'b0, 1'b1, 1'b1);
				made = 1'b1;
			end
			cont_left = '0;
			cp_accum = '0;
			cur_len = '0;
			point_index = '0;
		end
		return made;
	endfunction

	// Offers one beat, after a random gap, and returns at the edge that accepts it.
	task automatic push_byte(input logic [7:0] b, input logic eos, input logic typed,
			input decoded_t want);
		decoded_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		data_byte <= b;
		end_of_string <= eos;
		if (decode_byte(b, eos, res)) begin
			pending_points.push_back(typed ? want : res);
		end
		do @(posedge clk); while (byte_stall);
	endtask

	function automatic logic [7:0] lead_byte(input int n);
		case (n)
			1: return {1'b0, 7'($urandom)};
			2: return {3'b110, 5'($urandom)};
			3: return {4'b1110, 4'($urandom)};
			default: return {5'b11110, 3'($urandom)};
		endcase
	endfunction

	// Mostly well-formed characters, some noise bytes, and sometimes a cut-off tail.
	task automatic push_random_string(inout int sent);
		logic [7:0] str_bytes [$];
		int n_chars;
		int n;
		int k;
		str_bytes = {};
		n_chars = $urandom_range(12, 1);
		for (int c = 0; c < n_chars; c++) begin
			if ($urandom_range(99) < 12) begin
				str_bytes.push_back(8'($urandom));
			end else begin
				n = $urandom_range(4, 1);
				str_bytes.push_back(lead_byte(n));
				for (int j = 1; j < n; j++) begin
					str_bytes.push_back({2'b10, 6'($urandom)});
				end
			end
		end
		if ($urandom_range(99) < 20) begin
			n = $urandom_range(4, 2);
			k = $urandom_range(n - 2, 0);
			str_bytes.push_back(lead_byte(n));
			for (int j = 0; j < k; j++) begin
				str_bytes.push_back({2'b10, 6'($urandom)});
			end
		end
		foreach (str_bytes[i]) begin
			push_byte(str_bytes[i], i == str_bytes.size() - 1, 1'b0, '0);
		end
		sent += str_bytes.size();
	endtask

	always @(posedge clk) begin
		decoded_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_points.size() == 0) begin
				$error("result with nothing expected: code_point %0h", code_point);
				fail_count++;
			end else begin
				want = pending_points.pop_front();
				if (code_point !== want.cp) begin
					$error("code_point: expected %0h, got %0h", want.cp, code_point);
					fail_count++;
				end
				if (seq_bytes !== want.nbytes) begin
					$error("seq_bytes: expected %0d, got %0d", want.nbytes, seq_bytes);
					fail_count++;
				end
				if (bad_lead !== want.bad) begin
					$error("bad_lead: expected %0b, got %0b", want.bad, bad_lead);
					fail_count++;
				end
				if (truncated !== want.trunc) begin
					$error("truncated: expected %0b, got %0b", want.trunc, truncated);
					fail_count++;
				end
				if (char_index !== want.idx) begin
					$error("char_index: expected %0d, got %0d", want.idx, char_index);
					fail_count++;
				end
				if (last !== want.lst) begin
					$error("last: expected %0b, got %0b", want.lst, last);
					fail_count++;
				end
			end
		end
		result_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int sent;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			push_byte(directed_rows[i].b, directed_rows[i].eos, directed_rows[i].typed,
				directed_rows[i].want);
		end

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 65;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 65;
				end
				default: begin
					send_idle_pct = 25;
					recv_stall_pct = 25;
				end
			endcase
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				push_random_string(sent);
			end
		end

		byte_valid <= 1'b0;
		while (pending_points.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0 && pending_points.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
